### hdl/sjfk_pkg.sv
`timescale 1ns / 1ps
package sjfk_pkg;
    localparam int ATAN_LEN = 30;
    localparam int JOINTS = 6;
    localparam logic signed [33:0] PI_Q28 = 34'sd843314857;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [33:0] TWO_PI_Q28 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] TINY_Q30 = 34'sd1024;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [63:0] HALF_LSB = 64'sd536870912;

    localparam logic [2:0] CFG_D1 = 3'd0;
    localparam logic [2:0] CFG_A2 = 3'd1;
    localparam logic [2:0] CFG_A3 = 3'd2;
    localparam logic [2:0] CFG_D4 = 3'd3;
    localparam logic [2:0] CFG_D5 = 3'd4;
    localparam logic [2:0] CFG_D6 = 3'd5;

    typedef logic signed [33:0] t_q;
    typedef logic signed [63:0] t_acc;

    typedef struct packed {
        t_q r00; t_q r01; t_q r02;
        t_q r10; t_q r11; t_q r12;
        t_q r20; t_q r21; t_q r22;
        t_acc px; t_acc py; t_acc pz;
    } t_pose;

    function automatic t_q atan_tab(input int i);
        t_q v;
        case (i)
            0: v = 34'sd843314856;  1: v = 34'sd497837829;  2: v = 34'sd263043836;
            3: v = 34'sd133525158;  4: v = 34'sd67021686;   5: v = 34'sd33543515;
            6: v = 34'sd16775850;   7: v = 34'sd8388437;    8: v = 34'sd4194282;
            9: v = 34'sd2097149;    10: v = 34'sd1048575;   11: v = 34'sd524287;
            12: v = 34'sd262143;    13: v = 34'sd131071;    14: v = 34'sd65535;
            15: v = 34'sd32767;     16: v = 34'sd16383;     17: v = 34'sd8191;
            18: v = 34'sd4095;      19: v = 34'sd2047;      20: v = 34'sd1023;
            21: v = 34'sd511;       22: v = 34'sd255;       23: v = 34'sd127;
            24: v = 34'sd63;        25: v = 34'sd31;        26: v = 34'sd15;
            27: v = 34'sd7;         28: v = 34'sd3;         29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_acc rnd30(input t_acc v);
        t_acc t;
        t = v + HALF_LSB;
        return t >>> 30;
    endfunction
endpackage

### hdl/six_joint_forward_kinematics_core.sv
`timescale 1ns / 1ps
// channel  direction  handshake              words
// in       input      i_valid / o_ready      angle_j1 .. angle_j6
// out      output     o_valid / i_ready      pos_x .. pos_z, rot_00 .. rot_22
// cfg      input      i_cfg_we               i_cfg_index, i_cfg_data
// one word in and one out per cycle when neither side stalls
// path: CORDIC sine and cosine, each joint's link stages in turn, output register
// synchronous active-low reset empties the pipeline and restores link lengths
// a stall holds the whole pipeline when the output register is full and not taken
module six_joint_forward_kinematics_core #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic signed [31:0] i_angle_j1,
    input  logic signed [31:0] i_angle_j2,
    input  logic signed [31:0] i_angle_j3,
    input  logic signed [31:0] i_angle_j4,
    input  logic signed [31:0] i_angle_j5,
    input  logic signed [31:0] i_angle_j6,
    output logic o_valid,
    input  logic i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_rot_00,
    output logic signed [31:0] o_rot_01,
    output logic signed [31:0] o_rot_02,
    output logic signed [31:0] o_rot_10,
    output logic signed [31:0] o_rot_11,
    output logic signed [31:0] o_rot_12,
    output logic signed [31:0] o_rot_20,
    output logic signed [31:0] o_rot_21,
    output logic signed [31:0] o_rot_22,
    input  logic i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    import sjfk_pkg::*;

    logic signed [30:0] r_d1, r_a2, r_a3, r_d4, r_d5, r_d6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= 31'sd43620762;  r_a2 <= -31'sd114085069;
            r_a3 <= -31'sd105280387; r_d4 <= 31'sd35782446;
            r_d5 <= 31'sd26763015;  r_d6 <= 31'sd26736171;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_D1: r_d1 <= i_cfg_data;
                CFG_A2: r_a2 <= i_cfg_data;
                CFG_A3: r_a3 <= i_cfg_data;
                CFG_D4: r_d4 <= i_cfg_data;
                CFG_D5: r_d5 <= i_cfg_data;
                CFG_D6: r_d6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_ov;
    assign w_en = !r_ov || i_ready;
    assign o_ready = w_en;

    logic w_cv;
    t_q w_s [6];
    t_q w_c [6];
    sjfk_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_angles({i_angle_j6, i_angle_j5, i_angle_j4, i_angle_j3, i_angle_j2,
                   i_angle_j1}),
        .o_valid(w_cv), .o_sin(w_s), .o_cos(w_c)
    );

    // sine and cosine delay lines so that joint j meets its link stage
    t_q r_sd [6][20];
    t_q r_cd [6][20];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 6; j++) begin
                r_sd[j][0] <= w_s[j];
                r_cd[j][0] <= w_c[j];
                for (int k = 1; k < 20; k++) begin
                    r_sd[j][k] <= r_sd[j][k-1];
                    r_cd[j][k] <= r_cd[j][k-1];
                end
            end
        end
    end

    t_acc w_len [6];
    t_acc w_off [6];
    always_comb begin
        w_len[0] = '0; w_len[3] = '0; w_len[4] = '0; w_len[5] = '0;
        w_len[1] = {{33{r_a2[30]}}, r_a2};
        w_len[2] = {{33{r_a3[30]}}, r_a3};
        w_off[1] = '0; w_off[2] = '0;
        w_off[0] = {{33{r_d1[30]}}, r_d1};
        w_off[3] = {{33{r_d4[30]}}, r_d4};
        w_off[4] = {{33{r_d5[30]}}, r_d5};
        w_off[5] = {{33{r_d6[30]}}, r_d6};
    end

    logic  w_v [7];
    t_pose w_p [7];
    assign w_v[0] = w_cv;
    always_comb begin
        w_p[0] = '0;
        w_p[0].r00 = ONE_Q30; w_p[0].r11 = ONE_Q30; w_p[0].r22 = ONE_Q30;
    end

    for (genvar j = 0; j < 6; j++) begin : g_link
        t_q w_sj, w_cj;
        if (j == 0) begin : g_first
            assign w_sj = w_s[0];
            assign w_cj = w_c[0];
        end else begin : g_rest
            assign w_sj = r_sd[j][4*j-1];
            assign w_cj = r_cd[j][4*j-1];
        end
        sjfk_link #(.JOINT(j)) u_link (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_v[j]),
            .i_sin(w_sj), .i_cos(w_cj), .i_len(w_len[j]), .i_off(w_off[j]),
            .i_pose(w_p[j]), .o_valid(w_v[j+1]), .o_pose(w_p[j+1])
        );
    end

    function automatic logic signed [31:0] sat_p(input t_acc v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
    function automatic logic signed [31:0] sat_r(input t_q v);
        if (v > ONE_Q30) return 32'sh40000000;
        if (v < -ONE_Q30) return 32'shc0000000;
        return v[31:0];
    endfunction

    logic signed [31:0] r_o [12];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= w_v[6];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o[0] <= sat_p(w_p[6].px); r_o[1] <= sat_p(w_p[6].py);
            r_o[2] <= sat_p(w_p[6].pz);
            r_o[3] <= sat_r(w_p[6].r00); r_o[4] <= sat_r(w_p[6].r01);
            r_o[5] <= sat_r(w_p[6].r02); r_o[6] <= sat_r(w_p[6].r10);
            r_o[7] <= sat_r(w_p[6].r11); r_o[8] <= sat_r(w_p[6].r12);
            r_o[9] <= sat_r(w_p[6].r20); r_o[10] <= sat_r(w_p[6].r21);
            r_o[11] <= sat_r(w_p[6].r22);
        end
    end

    assign o_valid = r_ov;
    assign o_pos_x = r_o[0]; assign o_pos_y = r_o[1]; assign o_pos_z = r_o[2];
    assign o_rot_00 = r_o[3]; assign o_rot_01 = r_o[4]; assign o_rot_02 = r_o[5];
    assign o_rot_10 = r_o[6]; assign o_rot_11 = r_o[7]; assign o_rot_12 = r_o[8];
    assign o_rot_20 = r_o[9]; assign o_rot_21 = r_o[10]; assign o_rot_22 = r_o[11];
endmodule

### hdl/sjfk_cordic.sv
`timescale 1ns / 1ps
module sjfk_cordic #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic [6*32-1:0] i_angles,
    output logic o_valid,
    output sjfk_pkg::t_q o_sin [6],
    output sjfk_pkg::t_q o_cos [6]
);
    import sjfk_pkg::*;
    localparam int N = CORDIC_STAGES;

    logic     r_v [N+1];
    t_q       r_x [N+1][6];
    t_q       r_y [N+1][6];
    t_q       r_z [N+1][6];
    logic     r_f [N+1][6];
    logic     r_ov;
    t_q       r_s [6];
    t_q       r_c [6];

    t_q n_x0 [6];
    t_q n_z0 [6];
    logic n_f0 [6];

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            t_q a;
            a = {{2{i_angles[j*32+31]}}, i_angles[j*32 +: 32]};
            if (a > PI_Q28) a = a - TWO_PI_Q28;
            else if (a < -PI_Q28) a = a + TWO_PI_Q28;
            n_f0[j] = 1'b0;
            if (a > HALF_PI_Q28) begin
                a = a - PI_Q28; n_f0[j] = 1'b1;
            end else if (a < -HALF_PI_Q28) begin
                a = a + PI_Q28; n_f0[j] = 1'b1;
            end
            n_z0[j] = a <<< 2;
            n_x0[j] = GAIN_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= N; s++) r_v[s] <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < N; s++) r_v[s+1] <= r_v[s];
            r_ov <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 6; j++) begin
                r_x[0][j] <= n_x0[j];
                r_y[0][j] <= '0;
                r_z[0][j] <= n_z0[j];
                r_f[0][j] <= n_f0[j];
                for (int s = 0; s < N; s++) begin
                    if (!r_z[s][j][33]) begin
                        r_x[s+1][j] <= r_x[s][j] - (r_y[s][j] >>> s);
                        r_y[s+1][j] <= r_y[s][j] + (r_x[s][j] >>> s);
                        r_z[s+1][j] <= r_z[s][j] - atan_tab(s);
                    end else begin
                        r_x[s+1][j] <= r_x[s][j] + (r_y[s][j] >>> s);
                        r_y[s+1][j] <= r_y[s][j] - (r_x[s][j] >>> s);
                        r_z[s+1][j] <= r_z[s][j] + atan_tab(s);
                    end
                    r_f[s+1][j] <= r_f[s][j];
                end
                begin
                    t_q xc, yc;
                    xc = r_f[N][j] ? -r_x[N][j] : r_x[N][j];
                    yc = r_f[N][j] ? -r_y[N][j] : r_y[N][j];
                    if (xc > -TINY_Q30 && xc < TINY_Q30) xc = '0;
                    if (yc > -TINY_Q30 && yc < TINY_Q30) yc = '0;
                    r_c[j] <= xc;
                    r_s[j] <= yc;
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_sin = r_s;
    assign o_cos = r_c;
endmodule

### hdl/sjfk_link.sv
`timescale 1ns / 1ps
module sjfk_link #(
    parameter int JOINT = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  sjfk_pkg::t_q i_sin,
    input  sjfk_pkg::t_q i_cos,
    input  sjfk_pkg::t_acc i_len,
    input  sjfk_pkg::t_acc i_off,
    input  sjfk_pkg::t_pose i_pose,
    output logic o_valid,
    output sjfk_pkg::t_pose o_pose
);
    import sjfk_pkg::*;

    // per-row products, then rounding and accumulation
    logic r_v1, r_v2, r_v3, r_v4;
    t_q   r_s1, r_c1;
    t_acc r_la1, r_ls1;
    t_pose r_p1, r_p2, r_p3;
    t_acc r_m [3][4];
    t_acc r_l0, r_l1, r_off2;
    t_q   r_sv, r_cv;
    t_pose r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    t_q rm [3][3];
    t_q rp [3][3];
    always_comb begin
        rm[0][0] = r_p2.r00; rm[0][1] = r_p2.r01; rm[0][2] = r_p2.r02;
        rm[1][0] = r_p2.r10; rm[1][1] = r_p2.r11; rm[1][2] = r_p2.r12;
        rm[2][0] = r_p2.r20; rm[2][1] = r_p2.r21; rm[2][2] = r_p2.r22;
        rp[0][0] = r_p3.r00; rp[0][1] = r_p3.r01; rp[0][2] = r_p3.r02;
        rp[1][0] = r_p3.r10; rp[1][1] = r_p3.r11; rp[1][2] = r_p3.r12;
        rp[2][0] = r_p3.r20; rp[2][1] = r_p3.r21; rp[2][2] = r_p3.r22;
    end

    t_acc n_q [3][3];
    t_acc n_lp [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            t_acc m0, m1, m2;
            m0 = r_m[r][0];
            m1 = r_m[r][1];
            m2 = {{30{rp[r][2][33]}}, rp[r][2]};
            n_q[r][0] = rnd30(r_m[r][2]);
            case (JOINT)
                0, 3: begin
                    // twist +pi/2
                    n_q[r][1] = m2;
                    n_q[r][2] = rnd30(-r_m[r][3]);
                end
                4: begin
                    n_q[r][1] = -m2;
                    n_q[r][2] = rnd30(r_m[r][3]);
                end
                default: begin
                    n_q[r][1] = rnd30(r_m[r][3]);
                    n_q[r][2] = m2;
                end
            endcase
            n_lp[r] = rnd30(m0 + m1 + r_off2 * {{30{rp[r][2][33]}}, rp[r][2]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= i_sin; r_c1 <= i_cos;
            r_la1 <= i_len * {{30{i_cos[33]}}, i_cos};
            r_ls1 <= i_len * {{30{i_sin[33]}}, i_sin};
            r_p1 <= i_pose;
            r_off2 <= i_off;
            r_l0 <= rnd30(r_la1);
            r_l1 <= rnd30(r_ls1);
            r_sv <= r_s1; r_cv <= r_c1;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            for (int r = 0; r < 3; r++) begin
                r_m[r][0] <= r_l0 * {{30{rm[r][0][33]}}, rm[r][0]};
                r_m[r][1] <= r_l1 * {{30{rm[r][1][33]}}, rm[r][1]};
            end
            for (int r = 0; r < 3; r++) begin
                r_m[r][2] <= {{30{rm[r][0][33]}}, rm[r][0]} * {{30{r_cv[33]}}, r_cv}
                           + {{30{rm[r][1][33]}}, rm[r][1]} * {{30{r_sv[33]}}, r_sv};
                r_m[r][3] <= {{30{rm[r][1][33]}}, rm[r][1]} * {{30{r_cv[33]}}, r_cv}
                           - {{30{rm[r][0][33]}}, rm[r][0]} * {{30{r_sv[33]}}, r_sv};
            end
            r_o.r00 <= n_q[0][0][33:0]; r_o.r01 <= n_q[0][1][33:0];
            r_o.r02 <= n_q[0][2][33:0];
            r_o.r10 <= n_q[1][0][33:0]; r_o.r11 <= n_q[1][1][33:0];
            r_o.r12 <= n_q[1][2][33:0];
            r_o.r20 <= n_q[2][0][33:0]; r_o.r21 <= n_q[2][1][33:0];
            r_o.r22 <= n_q[2][2][33:0];
            r_o.px <= r_p3.px + n_lp[0];
            r_o.py <= r_p3.py + n_lp[1];
            r_o.pz <= r_p3.pz + n_lp[2];
        end
    end

    assign o_valid = r_v4;
    assign o_pose = r_o;
endmodule
